// ===== src/ihp_pkg.sv =====
package ihp_pkg;

    // character codes the parser looks for
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_X_LOW  = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;

    // at most four parts are kept
    localparam logic [2:0] PART_MAX  = 3'd4;

    // part values saturate here
    localparam logic [32:0] SAT_LIMIT = 33'h1_0000_0000;

    // radix phase of the part being read
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ZERO  = 3'd1,
        PH_DEC   = 3'd2,
        PH_OCT   = 3'd3,
        PH_HEX   = 3'd4
    } t_phase;

    // first error seen inside a part
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd2,
        ERR_DIGIT = 2'd3
    } t_part_err;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DIGIT    = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    // closed view of the host text after the final part
    typedef struct packed {
        logic [2:0]        count;
        logic [3:0][32:0]  vals;
        t_part_err         err;
        logic              too_many;
    } t_close_info;

endpackage

// ===== src/ihp_digit_step.sv =====
module ihp_digit_step (
    input  logic [7:0]      i_ch,
    input  logic [32:0]     i_acc,
    input  ihp_pkg::t_phase i_phase,
    input  logic [1:0]      i_chars,
    output logic [32:0]     o_acc,
    output ihp_pkg::t_phase o_phase,
    output logic [1:0]      o_chars,
    output logic            o_bad
);
    import ihp_pkg::*;

    // hex digit value, 31 for anything that is not a digit
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd31;
        if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    logic [4:0]  w_digit;
    logic [4:0]  w_radix;
    logic        w_add;
    logic [36:0] w_wide;
    logic [36:0] w_prod;
    logic [36:0] w_sum;

    always_comb begin
        w_digit = digit_value(i_ch);
        o_chars = (i_chars == 2'd3) ? 2'd3 : i_chars + 2'd1;
        o_phase = i_phase;
        w_add   = 1'b1;
        w_radix = 5'd16;

        // phase walk: leading zero, then x for hex or octal digits
        unique case (i_phase)
            PH_START: begin
                if (i_ch == CH_ZERO) begin
                    o_phase = PH_ZERO;
                    w_add   = 1'b0;
                end else begin
                    o_phase = PH_DEC;
                    w_radix = 5'd10;
                end
            end
            PH_ZERO: begin
                if (i_ch == CH_X_LOW || i_ch == CH_X_UP) begin
                    o_phase = PH_HEX;
                    w_add   = 1'b0;
                end else begin
                    o_phase = PH_OCT;
                    w_radix = 5'd8;
                end
            end
            PH_DEC:  w_radix = 5'd10;
            PH_OCT:  w_radix = 5'd8;
            PH_HEX:  w_radix = 5'd16;
            default: w_radix = 5'd16;
        endcase

        // shift-add by the constant radix
        w_wide = {4'd0, i_acc};
        unique case (w_radix)
            5'd8:    w_prod = w_wide << 3;
            5'd10:   w_prod = (w_wide << 3) + (w_wide << 1);
            default: w_prod = w_wide << 4;
        endcase
        w_sum = w_prod + {32'd0, w_digit};

        o_bad = w_add && (w_digit >= w_radix);
        o_acc = i_acc;
        if (w_add && !o_bad) begin
            o_acc = (w_sum > {4'd0, SAT_LIMIT}) ? SAT_LIMIT : w_sum[32:0];
        end
    end

endmodule

// ===== src/ihp_part_track.sv =====
module ihp_part_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_no_char,
    input  logic                 i_last,
    output ihp_pkg::t_close_info o_info
);
    import ihp_pkg::*;

    logic [2:0]        r_count, n_count;
    logic [3:0][32:0]  r_vals;
    logic [32:0]       r_acc, n_acc;
    t_phase            r_phase, n_phase;
    logic [1:0]        r_chars, n_chars;
    t_part_err         r_err, n_err;
    logic              r_too_many, n_too_many;

    logic [32:0]       w_d_acc;
    t_phase            w_d_phase;
    logic [1:0]        w_d_chars;
    logic              w_d_bad;

    logic              w_is_dot, w_is_chr;
    logic [32:0]       w_a_acc;
    logic [1:0]        w_a_chars;
    t_part_err         w_a_err;
    logic [2:0]        w_c1_count, w_c2_count;
    logic [3:0][32:0]  w_c1_vals, w_c2_vals;
    t_part_err         w_c1_err, w_c2_err;
    logic              w_c1_tmp, w_c2_tmp;
    logic [32:0]       w_f_acc;
    logic [1:0]        w_f_chars;

    ihp_digit_step u_digit (
        .i_ch    (i_ch),
        .i_acc   (r_acc),
        .i_phase (r_phase),
        .i_chars (r_chars),
        .o_acc   (w_d_acc),
        .o_phase (w_d_phase),
        .o_chars (w_d_chars),
        .o_bad   (w_d_bad)
    );

    always_comb begin
        w_is_dot = !i_no_char && (i_ch == CH_DOT);
        w_is_chr = !i_no_char && (i_ch != CH_DOT);

        // character into the open part
        w_a_acc   = w_is_chr ? w_d_acc : r_acc;
        w_a_chars = w_is_chr ? w_d_chars : r_chars;
        w_a_err   = r_err;
        if (w_is_chr && w_d_bad && r_err == ERR_NONE) w_a_err = ERR_DIGIT;

        // dot closes the open part
        w_c1_count = r_count;
        w_c1_vals  = r_vals;
        w_c1_err   = w_a_err;
        w_c1_tmp   = r_too_many;
        if (w_is_dot) begin
            if (r_chars == 2'd0 && w_c1_err == ERR_NONE) w_c1_err = ERR_EMPTY;
            if (r_count >= PART_MAX) begin
                w_c1_tmp = 1'b1;
            end else begin
                w_c1_vals[r_count[1:0]] = r_acc;
                w_c1_count = r_count + 3'd1;
            end
        end
        w_f_acc   = w_is_dot ? 33'd0 : w_a_acc;
        w_f_chars = w_is_dot ? 2'd0 : w_a_chars;

        // final close; a trailing empty part is dropped
        w_c2_count = w_c1_count;
        w_c2_vals  = w_c1_vals;
        w_c2_err   = w_c1_err;
        w_c2_tmp   = w_c1_tmp;
        if (!(w_f_chars == 2'd0 && w_c1_count != 3'd0)) begin
            if (w_f_chars == 2'd0 && w_c2_err == ERR_NONE) w_c2_err = ERR_EMPTY;
            if (w_c1_count >= PART_MAX) begin
                w_c2_tmp = 1'b1;
            end else begin
                w_c2_vals[w_c1_count[1:0]] = w_f_acc;
                w_c2_count = w_c1_count + 3'd1;
            end
        end
        o_info.count    = w_c2_count;
        o_info.vals     = w_c2_vals;
        o_info.err      = w_c2_err;
        o_info.too_many = w_c2_tmp;

        // next state: back to start after the last item
        n_count    = r_count;
        n_acc      = r_acc;
        n_phase    = r_phase;
        n_chars    = r_chars;
        n_err      = r_err;
        n_too_many = r_too_many;
        if (i_step) begin
            if (i_last) begin
                n_count    = 3'd0;
                n_acc      = 33'd0;
                n_phase    = PH_START;
                n_chars    = 2'd0;
                n_err      = ERR_NONE;
                n_too_many = 1'b0;
            end else begin
                n_count    = w_c1_count;
                n_acc      = w_f_acc;
                n_phase    = w_is_dot ? PH_START : (w_is_chr ? w_d_phase : r_phase);
                n_chars    = w_f_chars;
                n_err      = w_c1_err;
                n_too_many = w_c1_tmp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 3'd0;
            r_acc      <= 33'd0;
            r_phase    <= PH_START;
            r_chars    <= 2'd0;
            r_err      <= ERR_NONE;
            r_too_many <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_acc      <= n_acc;
            r_phase    <= n_phase;
            r_chars    <= n_chars;
            r_err      <= n_err;
            r_too_many <= n_too_many;
        end
    end

    // stored part values; only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_step && !i_last) r_vals <= w_c1_vals;
    end

endmodule

// ===== src/ihp_result.sv =====
module ihp_result (
    input  ihp_pkg::t_close_info i_info,
    output logic [31:0]          o_address,
    output logic [2:0]           o_status
);
    import ihp_pkg::*;

    t_status     w_status;
    logic [31:0] w_addr;
    logic        w_range;

    always_comb begin
        w_range = 1'b0;
        w_addr  = 32'd0;

        // range checks and byte placement by part count
        unique case (i_info.count)
            3'd1: begin
                w_range = i_info.vals[0][32];
                w_addr  = i_info.vals[0][31:0];
            end
            3'd2: begin
                w_range = (|i_info.vals[0][32:8]) || (|i_info.vals[1][32:24]);
                w_addr  = {i_info.vals[0][7:0], i_info.vals[1][23:0]};
            end
            3'd3: begin
                w_range = (|i_info.vals[0][32:8]) || (|i_info.vals[1][32:8])
                       || (|i_info.vals[2][32:16]);
                w_addr  = {i_info.vals[0][7:0], i_info.vals[1][7:0],
                           i_info.vals[2][15:0]};
            end
            3'd4: begin
                w_range = (|i_info.vals[0][32:8]) || (|i_info.vals[1][32:8])
                       || (|i_info.vals[2][32:8]) || (|i_info.vals[3][32:8]);
                w_addr  = {i_info.vals[0][7:0], i_info.vals[1][7:0],
                           i_info.vals[2][7:0], i_info.vals[3][7:0]};
            end
            default: begin
                w_range = 1'b0;
                w_addr  = 32'd0;
            end
        endcase

        // error priority
        if (i_info.too_many) begin
            w_status = ST_TOO_MANY;
        end else if (i_info.err == ERR_EMPTY) begin
            w_status = ST_EMPTY;
        end else if (i_info.err == ERR_DIGIT) begin
            w_status = ST_DIGIT;
        end else if (i_info.count == 3'd0 || i_info.count > PART_MAX) begin
            w_status = ST_EMPTY;
        end else if (w_range) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end

        o_status  = w_status;
        o_address = (w_status == ST_OK) ? w_addr : 32'd0;
    end

endmodule

// ===== src/ipv4_host_text_parser.sv =====
// Dotted IPv4 host text parser.
// Input channel: one character per item on i_ch, with i_no_char for an item
// that carries none (empty text) and i_last on the final item. An item is
// taken on a clock edge with i_valid high and o_stall low.
// Output channel: one item per host text, given after the item marked last,
// with o_address and o_status (0 ok, 1 too many parts, 2 empty part,
// 3 bad digit, 4 value too large); o_address is zero on error. It is taken
// on an edge with o_valid high and i_stall low.
// Throughput: one character per cycle while o_stall is low. Each item goes
// through an input register and then one pass of digit and close logic into
// the result register, so o_valid rises when the last item moves on from the
// input register. The per-character work is one shift-add by the radix.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a host. After every result the parser also goes
// back to the start. While i_stall holds a result, one more item can sit
// in the input register before o_stall rises.
module ipv4_host_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_no_char,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_address,
    output logic [2:0]  o_status
);
    import ihp_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_ch;
    logic        r_no_char;
    logic        r_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_address;
    logic [2:0]  r_status;

    logic        w_advance;
    logic        w_take;
    logic        w_step;
    t_close_info w_info;
    logic [31:0] w_address;
    logic [2:0]  w_status;

    // handshake: input register moves on when the result register is free
    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_take    = i_valid && !o_stall;
    assign w_step    = r_in_valid && w_advance;

    ihp_part_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_ch      (r_ch),
        .i_no_char (r_no_char),
        .i_last    (r_last),
        .o_info    (w_info)
    );

    ihp_result u_result (
        .i_info    (w_info),
        .o_address (w_address),
        .o_status  (w_status)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) n_in_valid = 1'b1;
        else if (w_step) n_in_valid = 1'b0;

        n_out_valid = r_out_valid;
        if (w_step && r_last) n_out_valid = 1'b1;
        else if (!i_stall) n_out_valid = 1'b0;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ch      <= i_ch;
            r_no_char <= i_no_char;
            r_last    <= i_last;
        end
        if (w_step && r_last) begin
            r_address <= w_address;
            r_status  <= w_status;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_address = r_address;
    assign o_status  = r_status;

endmodule

// ===== bench/ipv4_host_text_parser_tb.sv =====
`timescale 1ns / 100ps

module ipv4_host_text_parser_tb;

    import ihp_pkg::*;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // one expected output item
    typedef struct {
        logic [31:0] addr;
        t_status     status;
    } t_host_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_ch;
    logic        i_no_char;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_address;
    logic [2:0]  o_status;

    ipv4_host_text_parser DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_ch      (i_ch),
        .i_no_char (i_no_char),
        .i_last    (i_last),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_address (o_address),
        .o_status  (o_status)
    );

    // parser state mirrored by the predictor
    logic [2:0]  hp_count;
    logic [32:0] hp_vals [4];
    logic [32:0] hp_acc;
    t_phase      hp_phase;
    logic [1:0]  hp_chars;
    t_part_err   hp_err;
    logic        hp_too_many;

    t_host_result host_results_q [$];
    logic [7:0]   host_text_q [$];
    t_host_result want;

    int  errors;
    int  items_sent;
    int  hosts_sent;
    int  results_checked;
    int  idle_cycles;
    int  stall_cycles;
    int  status_count [5];
    bit  hold_req;
    bit  no_idle;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void hp_new_part();
        hp_acc   = '0;
        hp_phase = PH_START;
        hp_chars = '0;
    endfunction

    function automatic void hp_reset();
        hp_count = '0;
        foreach (hp_vals[i]) hp_vals[i] = '0;
        hp_err      = ERR_NONE;
        hp_too_many = 1'b0;
        hp_new_part();
    endfunction

    function automatic void hp_note(t_part_err e);
        if (hp_err == ERR_NONE) hp_err = e;
    endfunction

    function automatic void hp_add_digit(logic [7:0] c, int radix);
        int d;
        longint unsigned v;
        if (c >= "0" && c <= "9") d = c - CH_ZERO;
        else if (c >= "a" && c <= "f") d = c - "a" + 10;
        else if (c >= "A" && c <= "F") d = c - "A" + 10;
        else d = 99;
        if (d >= radix) begin
            hp_note(ERR_DIGIT);
            return;
        end
        v = 64'(hp_acc) * radix + d;
        hp_acc = (v > 64'(SAT_LIMIT)) ? SAT_LIMIT : v[32:0];
    endfunction

    function automatic void hp_take_char(logic [7:0] c);
        if (hp_chars < 2'd3) hp_chars++;
        case (hp_phase)
            PH_START: begin
                if (c == CH_ZERO) begin
                    hp_phase = PH_ZERO;
                end else begin
                    hp_phase = PH_DEC;
                    hp_add_digit(c, 10);
                end
            end
            PH_ZERO: begin
                if (c == CH_X_LOW || c == CH_X_UP) begin
                    hp_phase = PH_HEX;
                end else begin
                    hp_phase = PH_OCT;
                    hp_add_digit(c, 8);
                end
            end
            PH_DEC:  hp_add_digit(c, 10);
            PH_OCT:  hp_add_digit(c, 8);
            default: hp_add_digit(c, 16);
        endcase
    endfunction

    function automatic void hp_close_part(bit final_part);
        if (hp_chars == 0) begin
            // a trailing empty part is dropped
            if (final_part && hp_count > 0) return;
            hp_note(ERR_EMPTY);
        end
        if (hp_count >= PART_MAX) begin
            hp_too_many = 1'b1;
        end else begin
            hp_vals[hp_count] = hp_acc;
            hp_count++;
        end
    endfunction

    function automatic void hp_finish();
        t_host_result r;
        int n;
        longint unsigned a;
        hp_close_part(1'b1);
        n = hp_count;
        r.addr   = '0;
        r.status = ST_OK;
        if (hp_too_many) begin
            r.status = ST_TOO_MANY;
        end else if (hp_err != ERR_NONE) begin
            r.status = (hp_err == ERR_EMPTY) ? ST_EMPTY : ST_DIGIT;
        end else begin
            for (int i = 0; i < n - 1; i++)
                if (hp_vals[i] > 33'd255) r.status = ST_RANGE;
            if (r.status == ST_OK && 64'(hp_vals[n-1]) >= (64'd1 << (8 * (5 - n))))
                r.status = ST_RANGE;
            if (r.status == ST_OK) begin
                a = 64'(hp_vals[n-1]);
                for (int i = 0; i < n - 1; i++)
                    a += 64'(hp_vals[i]) << (8 * (3 - i));
                r.addr = a[31:0];
            end
        end
        host_results_q.insert(host_results_q.size(), r);
        hp_reset();
    endfunction

    function automatic void hp_predict(logic [7:0] c, logic no_char, logic last);
        if (!no_char) begin
            if (c == CH_DOT) begin
                hp_close_part(1'b0);
                hp_new_part();
            end else begin
                hp_take_char(c);
            end
        end
        if (last) hp_finish();
    endfunction

    // ---------------------------------------------------------------
    // sender: called and returns at a falling edge
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic no_char, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_ch      <= c;
        i_no_char <= no_char;
        i_last    <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hp_predict(c, no_char, last);
        if (!no_char || last) items_sent++;
        @(negedge i_clk);
    endtask

    // append one character to the host text
    function automatic void text_add(logic [7:0] c);
        host_text_q.insert(host_text_q.size(), c);
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_add(s[i]);
    endtask

    // send the queued text; optionally close with a char-less item and
    // sprinkle ignored char-less items in between
    task automatic send_host(input bit end_no_char, input bit sprinkle);
        int len;
        len = host_text_q.size();
        for (int i = 0; i < len; i++) begin
            if (sprinkle && $urandom_range(0, 15) == 0)
                send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            send_char(host_text_q[i], 1'b0, (i == len - 1) && !end_no_char);
        end
        if (len == 0 || end_no_char)
            send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        hosts_sent++;
    endtask

    task automatic run_text(input string s, input bit end_no_char);
        host_text_q.delete();
        push_str(s);
        send_host(end_no_char, 1'b0);
    endtask

    // one random part, sized against the bound it must stay under
    task automatic push_part(input longint unsigned bound);
        longint unsigned v;
        int form;
        int digits;
        string s;
        case ($urandom_range(0, 9))
            0:       v = bound - 1;
            1:       v = bound;
            2:       v = 0;
            3:       v = {$urandom, $urandom} & 64'h3_FFFF_FFFF;
            default: v = longint'($urandom) % bound;
        endcase
        form = $urandom_range(0, 15);
        if (form == 0) begin
            // empty part
        end else if (form == 1) begin
            push_str($urandom_range(0, 1) ? "0x" : "0X");
        end else if (form == 2) begin
            // long decimal to drive the accumulator into saturation
            digits = $urandom_range(11, 20);
            text_add(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (digits - 1) text_add(CH_ZERO + 8'($urandom_range(0, 9)));
        end else if (form <= 5) begin
            s = $sformatf("%0h", v);
            if ($urandom_range(0, 1)) s = s.toupper();
            push_str($urandom_range(0, 1) ? "0x" : "0X");
            push_str(s);
        end else if (form <= 8) begin
            push_str(v == 0 ? "0" : $sformatf("0%0o", v));
        end else begin
            push_str($sformatf("%0d", v));
        end
    endtask

    // mostly dotted numbers, some broken ones and some plain noise
    task automatic build_random_host();
        int nparts;
        int kept;
        int len;
        host_text_q.delete();
        nparts = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) nparts = $urandom_range(5, 6);
        kept = (nparts > 4) ? 4 : nparts;
        for (int p = 0; p < nparts; p++) begin
            if (p > 0) text_add(CH_DOT);
            push_part(p == nparts - 1 ? (64'd1 << (8 * (5 - kept))) : 64'd256);
        end
        if ($urandom_range(0, 9) == 0) text_add(CH_DOT);
        len = host_text_q.size();
        if (len > 0 && $urandom_range(0, 7) == 0)
            host_text_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0)
            host_text_q.insert($urandom_range(0, len), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 19) == 0) begin
            host_text_q.delete();
            repeat ($urandom_range(1, 6)) text_add(8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: draws a stall per result, or one long hold on request
    // ---------------------------------------------------------------
    initial begin : result_taker
        int wait_cycles;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
                if (wait_cycles > 0) begin
                    i_stall <= 1'b1;
                    repeat (wait_cycles) @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (host_results_q.size() == 0) begin
                $error("result with none expected: address %h status %0d",
                       o_address, o_status);
                errors++;
            end else begin
                want = host_results_q.pop_front();
                if (o_address !== want.addr) begin
                    $error("address: expected %h actual %h", want.addr, o_address);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, o_status);
                    errors++;
                end
            end
            if (o_status <= 3'd4) status_count[o_status]++;
            results_checked++;
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n && o_stall) stall_cycles++;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ipv4_host_text_parser_tb failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic wait_results_done();
        while (host_results_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // empty text, lone dot, trailing dot, empty middle part
    task automatic test_empty_parts();
        run_text("", 1'b0);
        run_text(".", 1'b0);
        run_text("1.2.3.4.", 1'b0);
        run_text("1..2", 1'b1);
    endtask

    task automatic test_dotted_quads();
        run_text("255.255.255.255", 1'b0);
        run_text("0.0.0.0", 1'b1);
    endtask

    // hex, octal, bare prefixes and the widest last parts
    task automatic test_radix_forms();
        run_text("0x7F.0X1.017.9", 1'b0);
        run_text("0x", 1'b0);
        run_text("0", 1'b1);
        run_text("0xFFFFFFFF", 1'b0);
        run_text("037777777777", 1'b0);
    endtask

    // too many parts, bad digits, values too large, saturation and the size bounds
    task automatic test_error_cases();
        run_text("1.2.3.4.5", 1'b0);
        run_text("0x0x1", 1'b0);
        run_text("-1", 1'b0);
        run_text("08", 1'b0);
        run_text("256.1", 1'b0);
        run_text("1.16777216", 1'b0);
        run_text("99999999999", 1'b0);
    endtask

    task automatic test_random_hosts();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if (hosts_sent % 20 == 0) no_idle = ($urandom_range(0, 4) == 0);
            build_random_host();
            send_host($urandom_range(0, 7) == 0, 1'b1);
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while texts keep coming, so the input stalls
    task automatic test_output_hold();
        i_valid <= 1'b0;
        wait_results_done();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        repeat (12) begin
            build_random_host();
            send_host(1'b0, 1'b0);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_ch      = '0;
        i_no_char = 1'b0;
        i_last    = 1'b0;
        hp_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_parts();
        test_dotted_quads();
        test_radix_forms();
        test_error_cases();
        test_output_hold();
        test_random_hosts();

        i_valid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d host texts (%0d items), checked %0d results, input stalled %0d cycles.",
                 hosts_sent, items_sent, results_checked, stall_cycles);
        $display("Results: ok %0d, too many parts %0d, empty part %0d, bad digit %0d, too large %0d.",
                 status_count[0], status_count[1], status_count[2], status_count[3],
                 status_count[4]);
        if (errors == 0) begin
            $display("ipv4_host_text_parser_tb passed");
        end else begin
            $display("ipv4_host_text_parser_tb failed");
        end
        $finish;
    end

endmodule

// ===== ipv4_host_text_parser.f =====
src/ihp_pkg.sv
src/ihp_digit_step.sv
src/ihp_part_track.sv
src/ihp_result.sv
src/ipv4_host_text_parser.sv
bench/ipv4_host_text_parser_tb.sv
